FILE: rtl/mfd_pkg.sv
// Shared constants and types for the modulated fractional delay block.
// No dependencies; imported by modulated_fractional_delay.
package mfd_pkg;

    // Field widths
    localparam int AUDIO_W = 16;
    localparam int CFG_W   = 12;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Default sizing
    localparam int DEPTH_DEF     = 4096;
    localparam int FRAC_BITS_DEF = 10;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY  = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [CFG_W-1:0] BASE_DELAY_RST = CFG_W'(0);
    localparam logic [CFG_W-1:0] MAX_DELAY_RST  = CFG_W'(4094);

    // Where a read sample comes from
    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_FWD,
        SRC_ZERO
    } t_src;

endpackage

FILE: rtl/modulated_fractional_delay.sv
// Modulated delay line with linear interpolation between adjacent stored samples.
// Each request passes through D1, D2, two store reads, A and P, then an output queue.
// The store's single read port (two reads per request) bounds the rate: no request can
// launch during the prior one's second read. A 4-entry queue decouples the output stall.
// Reset (synchronous, active low) clears the pointers, fill count and registers; the store
// reads as zero above the fill count, so there is no clearing pass. Depends on mfd_pkg.
module modulated_fractional_delay #(
    parameter int DEPTH     = mfd_pkg::DEPTH_DEF,
    parameter int FRAC_BITS = mfd_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [mfd_pkg::AUDIO_W-1:0]  i_audio_in,
    input  logic signed [mfd_pkg::AUDIO_W-1:0]  i_mod_offset,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [mfd_pkg::AUDIO_W-1:0]  o_audio_out
);
    import mfd_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int DW  = ((CFG_W + FRAC_BITS > AUDIO_W) ? CFG_W + FRAC_BITS : AUDIO_W) + 2;
    // reciprocal for whole % DEPTH, exact for all CFG_W-bit numerators
    localparam int RSH   = CFG_W + AW;
    localparam int RECIP = ((2 ** RSH) + DEPTH - 1) / DEPTH;
    localparam int PW    = RSH + CFG_W;
    localparam int QW    = CFG_W + AW + 1;
    localparam logic [AW:0] DEPTH_V = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FAW = $clog2(FIFO_DEPTH);
    localparam logic [FAW:0] FIFO_FULL = (FAW + 1)'(FIFO_DEPTH);
    localparam int PRW = AUDIO_W + 2 + FRAC_BITS;

    // configuration registers
    logic [CFG_W-1:0] r_base_delay;
    logic [CFG_W-1:0] r_max_delay;

    // stage D1: clamped delay
    logic                        r_d1_valid;
    logic signed [AUDIO_W-1:0]   r_d1_sample;
    logic [CFG_W-1:0]            r_d1_whole;
    logic [FRAC_BITS-1:0]        r_d1_frac;

    // stage D2: whole delay reduced modulo the depth
    logic                        r_d2_valid;
    logic signed [AUDIO_W-1:0]   r_d2_sample;
    logic [AW-1:0]               r_d2_w;
    logic [FRAC_BITS-1:0]        r_d2_frac;

    // memory stage, second read cycle
    logic                        r_m_ph1;
    logic signed [AUDIO_W-1:0]   r_m_sample;
    logic [AW-1:0]               r_m_i1;
    t_src                        r_m_src0;
    t_src                        r_m_src1;
    logic [FRAC_BITS-1:0]        r_m_frac;

    // stage A: ya resolved, yb arriving from the store
    logic                        r_a_valid;
    logic signed [AUDIO_W-1:0]   r_a_sample;
    logic signed [AUDIO_W-1:0]   r_a_ya;
    t_src                        r_a_src1;
    logic [FRAC_BITS-1:0]        r_a_frac;

    // stage P: product registered
    logic                        r_p_valid;
    logic signed [AUDIO_W-1:0]   r_p_ya;
    logic signed [PRW-1:0]       r_p_prod;

    // sample store and pointers
    logic signed [AUDIO_W-1:0]   r_mem [DEPTH];
    logic signed [AUDIO_W-1:0]   r_rd_data;
    logic [AW-1:0]               r_wp;
    logic [AW:0]                 r_fill;

    // output queue
    logic signed [AUDIO_W-1:0]   r_fifo [FIFO_DEPTH];
    logic [FAW-1:0]              r_fifo_wr;
    logic [FAW-1:0]              r_fifo_rd;
    logic [FAW:0]                r_fifo_count;
    logic [FAW:0]                r_credit;

    // handshake and flow
    logic accept;
    logic d1_move;
    logic launch;
    logic pop;
    logic cfg_write;

    // next values
    logic [CFG_W-1:0]           n_d1_whole;
    logic [FRAC_BITS-1:0]       n_d1_frac;
    logic [AW-1:0]              n_d2_w;
    logic [AW-1:0]              n_wp;
    logic [FAW:0]               n_credit;
    logic [FAW:0]               n_fifo_count;

    // delay arithmetic
    logic signed [DW-1:0]       delay_raw;
    logic signed [DW-1:0]       delay_hi;
    logic signed [DW-1:0]       delay_clamped;
    logic [PW-1:0]              recip_prod;
    logic [CFG_W-1:0]           quot;
    logic [QW-1:0]              quot_depth;
    logic [CFG_W-1:0]           rem;

    // addressing
    logic [AW:0]                addr_diff;
    logic [AW-1:0]              i0;
    logic [AW-1:0]              i1;
    logic [AW-1:0]              rd_addr;
    t_src                       src0;
    t_src                       src1;

    // interpolation
    logic signed [AUDIO_W-1:0]  ya_res;
    logic signed [AUDIO_W-1:0]  yb_res;
    logic signed [AUDIO_W:0]    diff;
    logic signed [PRW-1:0]      prod;
    logic signed [PRW-1:0]      quo_f;
    logic signed [AUDIO_W:0]    y_sum;

    // flow control
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign launch      = r_d2_valid && !r_m_ph1 && (r_credit < FIFO_FULL);
    assign d1_move     = r_d1_valid && (!r_d2_valid || launch);
    assign o_in_stall  = r_d1_valid && !d1_move;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_fifo_count != '0);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_audio_out = r_fifo[r_fifo_rd];

    // form and clamp the fixed-point delay
    always_comb begin
        delay_raw = $signed({{(DW - CFG_W - FRAC_BITS){1'b0}}, r_base_delay,
                             {FRAC_BITS{1'b0}}})
                  + $signed({{(DW - AUDIO_W){i_mod_offset[AUDIO_W-1]}}, i_mod_offset});
        delay_hi  = $signed({{(DW - CFG_W - FRAC_BITS){1'b0}}, r_max_delay,
                             {FRAC_BITS{1'b0}}});
        priority if (delay_raw < 0) begin
            delay_clamped = '0;
        end else if (delay_raw > delay_hi) begin
            delay_clamped = delay_hi;
        end else begin
            delay_clamped = delay_raw;
        end
        n_d1_whole = delay_clamped[FRAC_BITS +: CFG_W];
        n_d1_frac  = delay_clamped[FRAC_BITS-1:0];
    end

    // reduce the whole delay modulo the depth by reciprocal multiply
    always_comb begin
        recip_prod = PW'(r_d1_whole) * PW'(RECIP);
        quot       = recip_prod[RSH +: CFG_W];
        quot_depth = QW'(quot) * QW'(DEPTH_V);
        rem        = r_d1_whole - quot_depth[CFG_W-1:0];
        n_d2_w     = AW'(rem);
    end

    // read addresses and sources for the two taps
    always_comb begin
        addr_diff = {1'b0, r_wp} - {1'b0, r_d2_w};
        if (addr_diff[AW]) begin
            addr_diff = addr_diff + DEPTH_V;
        end
        i0 = addr_diff[AW-1:0];
        i1 = (i0 == '0) ? LAST_ADDR : (i0 - AW'(1));

        priority if (i0 == r_wp) begin
            src0 = SRC_FWD;
        end else if ({1'b0, i0} < r_fill) begin
            src0 = SRC_MEM;
        end else begin
            src0 = SRC_ZERO;
        end
        priority if (i1 == r_wp) begin
            src1 = SRC_FWD;
        end else if ({1'b0, i1} < r_fill) begin
            src1 = SRC_MEM;
        end else begin
            src1 = SRC_ZERO;
        end

        rd_addr = launch ? i0 : r_m_i1;
        n_wp    = (r_wp == LAST_ADDR) ? '0 : (r_wp + AW'(1));
    end

    // resolve taps and interpolate
    always_comb begin
        unique case (r_m_src0)
            SRC_FWD:  ya_res = r_m_sample;
            SRC_MEM:  ya_res = r_rd_data;
            default:  ya_res = '0;
        endcase
        unique case (r_a_src1)
            SRC_FWD:  yb_res = r_a_sample;
            SRC_MEM:  yb_res = r_rd_data;
            default:  yb_res = '0;
        endcase
        diff  = $signed({yb_res[AUDIO_W-1], yb_res}) - $signed({r_a_ya[AUDIO_W-1], r_a_ya});
        prod  = PRW'(diff) * $signed(PRW'({1'b0, r_a_frac}));
        quo_f = r_p_prod >>> FRAC_BITS;
        y_sum = $signed({r_p_ya[AUDIO_W-1], r_p_ya}) + quo_f[AUDIO_W:0];
    end

    // queue occupancy and reserved slots
    always_comb begin
        n_credit     = r_credit + (FAW + 1)'(launch) - (FAW + 1)'(pop);
        n_fifo_count = r_fifo_count + (FAW + 1)'(r_p_valid) - (FAW + 1)'(pop);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay <= BASE_DELAY_RST;
            r_max_delay  <= MAX_DELAY_RST;
            r_d1_valid   <= 1'b0;
            r_d2_valid   <= 1'b0;
            r_m_ph1      <= 1'b0;
            r_a_valid    <= 1'b0;
            r_p_valid    <= 1'b0;
            r_wp         <= '0;
            r_fill       <= '0;
            r_fifo_wr    <= '0;
            r_fifo_rd    <= '0;
            r_fifo_count <= '0;
            r_credit     <= '0;
        end else begin
            // take register writes, drop unknown indexes
            if (cfg_write) begin
                if (i_cfg_index == REG_BASE_DELAY) begin
                    r_base_delay <= i_cfg_data[CFG_W-1:0];
                end else if (i_cfg_index == REG_MAX_DELAY) begin
                    r_max_delay <= i_cfg_data[CFG_W-1:0];
                end
            end
            // advance the pipeline
            if (accept) begin
                r_d1_valid <= 1'b1;
            end else if (d1_move) begin
                r_d1_valid <= 1'b0;
            end
            if (d1_move) begin
                r_d2_valid <= 1'b1;
            end else if (launch) begin
                r_d2_valid <= 1'b0;
            end
            r_m_ph1   <= launch;
            r_a_valid <= r_m_ph1;
            r_p_valid <= r_a_valid;
            // advance write pointer and fill count
            if (launch) begin
                r_wp <= n_wp;
                if (r_fill != DEPTH_V) begin
                    r_fill <= r_fill + (AW + 1)'(1);
                end
            end
            // queue pointers
            if (r_p_valid) begin
                r_fifo_wr <= r_fifo_wr + FAW'(1);
            end
            if (pop) begin
                r_fifo_rd <= r_fifo_rd + FAW'(1);
            end
            r_fifo_count <= n_fifo_count;
            r_credit     <= n_credit;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_d1_sample <= i_audio_in;
            r_d1_whole  <= n_d1_whole;
            r_d1_frac   <= n_d1_frac;
        end
        if (d1_move) begin
            r_d2_sample <= r_d1_sample;
            r_d2_w      <= n_d2_w;
            r_d2_frac   <= r_d1_frac;
        end
        if (launch) begin
            r_m_sample <= r_d2_sample;
            r_m_i1     <= i1;
            r_m_src0   <= src0;
            r_m_src1   <= src1;
            r_m_frac   <= r_d2_frac;
        end
        r_a_sample <= r_m_sample;
        r_a_ya     <= ya_res;
        r_a_src1   <= r_m_src1;
        r_a_frac   <= r_m_frac;
        r_p_ya     <= r_a_ya;
        r_p_prod   <= prod;
        if (r_p_valid) begin
            r_fifo[r_fifo_wr] <= y_sum[AUDIO_W-1:0];
        end
    end

    // sample store: write the new sample, read one tap per cycle
    always_ff @(posedge i_clk) begin
        if (launch) begin
            r_mem[r_wp] <= r_d2_sample;
        end
        r_rd_data <= r_mem[rd_addr];
    end

endmodule
